FILE: rtl/drt_pkg.sv
// shared types, codes and defaults for the distance vector route table
`default_nettype none
package drt_pkg;

  // default parameter values
  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_ADDR_BITS   = 16;
  localparam int DEF_DELAY_BITS  = 16;

  // fixed port field widths
  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int DELAY_W = 16;
  localparam int RKIND_W = 2;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd0;
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ENTRY  = 2'd2;

  // result kinds
  localparam logic [RKIND_W-1:0] RES_FOUND    = 2'd0;
  localparam logic [RKIND_W-1:0] RES_NO_ROUTE = 2'd1;
  localparam logic [RKIND_W-1:0] RES_ACK      = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic scan_en;
    logic commit;
  } drt_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic done;
    logic respond;
  } drt_stat_t;

endpackage
`default_nettype wire

FILE: rtl/distance_vector_route_table_top.sv
// Distance vector route table, top level.
// Input channel (in_valid/in_ready): one transaction is a lookup, a routing
// packet header or a routing packet entry. Output channel (out_valid/
// out_ready): route found, no route, or packet acknowledge on the last item
// of a routing packet. cfg_we/cfg_wdata write this router's own address.
// Each transaction is loaded, then the route memory is scanned linearly at
// one entry per cycle through a registered read, then the transaction is
// committed; the scan stops early on a match. The single read port of the
// route memory sets this rate; a new transaction is accepted in the cycle
// after the commit.
// A result sits in the output register until taken; the block accepts the
// next transaction meanwhile and only holds at commit if that transaction
// also has a result and the output register is still full.
// Synchronous active low reset empties the table (route count zero), clears
// the packet gateway, link delay, dropped flag and own address; the route
// memory itself is not cleared and needs no clearing pass.
`default_nettype none
module distance_vector_route_table_top
  import drt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int DELAY_BITS  = DEF_DELAY_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [ADDR_W-1:0]  cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [ADDR_W-1:0]  in_address,
  input  wire logic [DELAY_W-1:0] in_delay_value,
  input  wire logic               in_last_entry,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [RKIND_W-1:0]      out_result_kind,
  output logic [ADDR_W-1:0]       out_gateway,
  output logic [DELAY_W-1:0]      out_route_delay,
  output logic                    out_table_full_dropped
);

  drt_cmd_t  cmd;
  drt_stat_t st;

  // controller
  drt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  // datapath
  drt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_BITS   (ADDR_BITS),
    .DELAY_BITS  (DELAY_BITS)
  ) u_datapath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_kind                (in_kind),
    .in_address             (in_address),
    .in_delay_value         (in_delay_value),
    .in_last_entry          (in_last_entry),
    .cmd                    (cmd),
    .st                     (st),
    .out_result_kind        (out_result_kind),
    .out_gateway            (out_gateway),
    .out_route_delay        (out_route_delay),
    .out_table_full_dropped (out_table_full_dropped)
  );

`ifndef ASSERT_OFF
  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && st.respond) |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

  // commit only once the scan has finished
  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> st.done)
    else $error("commit before scan finished");

  // an accepted transaction makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while a transaction is in flight");
`endif

endmodule
`default_nettype wire

FILE: rtl/drt_datapath.sv
// route memory, table scan, route update and result register
`default_nettype none
module drt_datapath
  import drt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_BITS   = DEF_ADDR_BITS,
  parameter int DELAY_BITS  = DEF_DELAY_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [ADDR_W-1:0]  cfg_wdata,
  input  wire logic [KIND_W-1:0]  in_kind,
  input  wire logic [ADDR_W-1:0]  in_address,
  input  wire logic [DELAY_W-1:0] in_delay_value,
  input  wire logic               in_last_entry,
  input  wire drt_cmd_t           cmd,
  output drt_stat_t               st,
  output logic [RKIND_W-1:0]      out_result_kind,
  output logic [ADDR_W-1:0]       out_gateway,
  output logic [DELAY_W-1:0]      out_route_delay,
  output logic                    out_table_full_dropped
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  // route memories, contents undefined until written
  logic [ADDR_BITS-1:0]  dest_mem [TABLE_DEPTH];
  logic [ADDR_BITS-1:0]  gw_mem   [TABLE_DEPTH];
  logic [DELAY_BITS-1:0] cost_mem [TABLE_DEPTH];

  // control and packet state
  logic [ADDR_W-1:0]     own_addr_r;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [ADDR_BITS-1:0]  pkt_gw_r, pkt_gw_nxt;
  logic [DELAY_BITS-1:0] pkt_delay_r, pkt_delay_nxt;
  logic                  dropped_r, dropped_nxt;

  // latched item
  logic [KIND_W-1:0]     kind_r;
  logic [ADDR_BITS-1:0]  addr_r;
  logic [DELAY_BITS-1:0] cost_r;
  logic                  last_r;
  logic                  skip_r;

  // scan pipeline
  logic [CNT_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  rd_pend_r, rd_pend_nxt;
  logic [IDX_W-1:0]      cmp_idx_r;
  logic [ADDR_BITS-1:0]  dest_q_r;
  logic [ADDR_BITS-1:0]  gw_q_r;
  logic [DELAY_BITS-1:0] cost_q_r;

  // result register
  logic [RKIND_W-1:0]    res_kind_r;
  logic [ADDR_W-1:0]     res_gw_r;
  logic [DELAY_W-1:0]    res_delay_r;
  logic                  res_drop_r;

  logic [ADDR_BITS-1:0]  in_addr_c;
  logic [DELAY_BITS-1:0] in_dval_c;
  logic [DELAY_BITS:0]   sum_c;
  logic [DELAY_BITS-1:0] entry_cost_c;
  logic                  issue_c;
  logic                  hit_c;
  logic                  miss_c;
  logic                  is_lookup_c;
  logic                  is_offer_c;
  logic                  full_c;
  logic                  drop_eff_c;
  logic                  wr_new_c;
  logic                  wr_cost_c;

  // input fields at internal widths
  assign in_addr_c = ADDR_BITS'(in_address);
  assign in_dval_c = DELAY_BITS'(in_delay_value);

  // saturating entry delay sum
  assign sum_c        = {1'b0, pkt_delay_r} + {1'b0, in_dval_c};
  assign entry_cost_c = sum_c[DELAY_BITS] ? {DELAY_BITS{1'b1}} : sum_c[DELAY_BITS-1:0];

  // scan status
  assign issue_c = (rd_idx_r != count_r);
  assign hit_c   = rd_pend_r && (dest_q_r == addr_r);
  assign miss_c  = !rd_pend_r && !issue_c;

  assign is_lookup_c = (kind_r == KIND_LOOKUP);
  assign is_offer_c  = ((kind_r == KIND_HEADER) || (kind_r == KIND_ENTRY)) && !skip_r;
  assign full_c      = (count_r == DEPTH_CNT);
  assign drop_eff_c  = dropped_r || (is_offer_c && !hit_c && full_c);
  assign wr_new_c    = cmd.commit && is_offer_c && !hit_c && !full_c;
  assign wr_cost_c   = cmd.commit && is_offer_c && hit_c && (cost_r < cost_q_r);

  // scan status: skipped items need no table search; a result is due for lookups and last packet items
  always_comb begin
    st.done    = skip_r || hit_c || miss_c;
    st.respond = is_lookup_c ||
                 (last_r && ((kind_r == KIND_HEADER) || (kind_r == KIND_ENTRY)));
  end

  // next state of control registers
  always_comb begin
    count_nxt     = count_r;
    pkt_gw_nxt    = pkt_gw_r;
    pkt_delay_nxt = pkt_delay_r;
    dropped_nxt   = dropped_r;
    rd_idx_nxt    = rd_idx_r;
    rd_pend_nxt   = rd_pend_r;
    if (cmd.load) begin
      rd_idx_nxt  = '0;
      rd_pend_nxt = 1'b0;
      if (in_kind == KIND_HEADER) begin
        pkt_gw_nxt    = in_addr_c;
        pkt_delay_nxt = in_dval_c;
        dropped_nxt   = 1'b0;
      end
    end else if (cmd.scan_en) begin
      rd_pend_nxt = issue_c;
      if (issue_c) begin
        rd_idx_nxt = rd_idx_r + 1'b1;
      end
    end else if (cmd.commit) begin
      dropped_nxt = drop_eff_c;
      if (wr_new_c) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r  <= '0;
      count_r     <= '0;
      pkt_gw_r    <= '0;
      pkt_delay_r <= '0;
      dropped_r   <= 1'b0;
      rd_idx_r    <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_addr_r <= cfg_wdata;
      end
      count_r     <= count_nxt;
      pkt_gw_r    <= pkt_gw_nxt;
      pkt_delay_r <= pkt_delay_nxt;
      dropped_r   <= dropped_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // latch the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      addr_r <= in_addr_c;
      last_r <= in_last_entry;
      cost_r <= (in_kind == KIND_HEADER) ? in_dval_c : entry_cost_c;
      skip_r <= ((in_kind == KIND_ENTRY) && (in_addr_c == ADDR_BITS'(own_addr_r))) ||
                ((in_kind != KIND_LOOKUP) && (in_kind != KIND_HEADER) &&
                 (in_kind != KIND_ENTRY));
    end
  end

  // memory read, one entry per scan cycle
  always_ff @(posedge clk) begin
    if (cmd.scan_en && issue_c) begin
      dest_q_r  <= dest_mem[rd_idx_r[IDX_W-1:0]];
      gw_q_r    <= gw_mem[rd_idx_r[IDX_W-1:0]];
      cost_q_r  <= cost_mem[rd_idx_r[IDX_W-1:0]];
      cmp_idx_r <= rd_idx_r[IDX_W-1:0];
    end
  end

  // memory write: new route at the fill point, or a lowered delay
  always_ff @(posedge clk) begin
    if (wr_new_c) begin
      dest_mem[count_r[IDX_W-1:0]] <= addr_r;
      gw_mem[count_r[IDX_W-1:0]]   <= pkt_gw_r;
      cost_mem[count_r[IDX_W-1:0]] <= cost_r;
    end else if (wr_cost_c) begin
      cost_mem[cmp_idx_r] <= cost_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit && st.respond) begin
      if (is_lookup_c) begin
        res_drop_r <= 1'b0;
        if (hit_c) begin
          res_kind_r  <= RES_FOUND;
          res_gw_r    <= ADDR_W'(gw_q_r);
          res_delay_r <= DELAY_W'(cost_q_r);
        end else begin
          res_kind_r  <= RES_NO_ROUTE;
          res_gw_r    <= '0;
          res_delay_r <= '0;
        end
      end else begin
        res_kind_r  <= RES_ACK;
        res_gw_r    <= '0;
        res_delay_r <= '0;
        res_drop_r  <= drop_eff_c;
      end
    end
  end

  assign out_result_kind        = res_kind_r;
  assign out_gateway            = res_gw_r;
  assign out_route_delay        = res_delay_r;
  assign out_table_full_dropped = res_drop_r;

endmodule
`default_nettype wire

FILE: rtl/drt_ctrl.sv
// controller state machine: accept, scan, commit and output valid
`default_nettype none
module drt_ctrl
  import drt_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire drt_stat_t st,
  output drt_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_busy_c;

  assign out_busy_c = out_valid_r && !out_ready;

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.scan_en = 1'b0;
    cmd.commit  = 1'b0;
    in_ready    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!st.done) begin
          cmd.scan_en = 1'b1;
        end else if (!(st.respond && out_busy_c)) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.commit && st.respond) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: test/tb_distance_vector_route_table_top.sv
// self-checking testbench for the distance vector route table top level
`timescale 1ns / 1ps
module tb_distance_vector_route_table_top;
  import drt_pkg::*;

  localparam int TABLE_SLOTS = DEF_TABLE_DEPTH;
  localparam int SETTLE_CYCLES = 2 * (DEF_TABLE_DEPTH + 3);
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 250;
  localparam int POOL_SIZE = 40;
  localparam int PHASE_ITEMS = 215;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // one input transaction and one result transaction
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [DELAY_W-1:0] dly;
    logic               last_ent;
  } route_item_t;

  typedef struct packed {
    logic [RKIND_W-1:0] kind;
    logic [ADDR_W-1:0]  gw;
    logic [DELAY_W-1:0] dly;
    logic               drop;
  } route_reply_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [ADDR_W-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [ADDR_W-1:0]  in_address = '0;
  logic [DELAY_W-1:0] in_delay_value = '0;
  logic               in_last_entry = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [RKIND_W-1:0] out_result_kind;
  logic [ADDR_W-1:0]  out_gateway;
  logic [DELAY_W-1:0] out_route_delay;
  logic               out_table_full_dropped;

  distance_vector_route_table_top DUT (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_wdata              (cfg_wdata),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .in_kind                (in_kind),
    .in_address             (in_address),
    .in_delay_value         (in_delay_value),
    .in_last_entry          (in_last_entry),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_result_kind        (out_result_kind),
    .out_gateway            (out_gateway),
    .out_route_delay        (out_route_delay),
    .out_table_full_dropped (out_table_full_dropped)
  );

  // predicted router state
  logic [ADDR_W-1:0]  tbl_dest [TABLE_SLOTS];
  logic [ADDR_W-1:0]  tbl_gw [TABLE_SLOTS];
  logic [DELAY_W-1:0] tbl_delay [TABLE_SLOTS];
  int                 tbl_count = 0;
  logic [ADDR_W-1:0]  pkt_gw = '0;
  logic [DELAY_W-1:0] pkt_link = '0;
  logic               pkt_drop = 1'b0;
  logic [ADDR_W-1:0]  my_addr = '0;

  route_item_t  route_items[$];
  route_reply_t pending_replies[$];
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

  logic steady_flow = 1'b0;
  int   fail_cnt = 0;
  int   items_sent = 0;
  int   reply_cnt = 0;
  int   n_found = 0;
  int   n_no_route = 0;
  int   n_ack = 0;
  int   n_dropped = 0;
  int   n_settings = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // index of the route for a destination, -1 when unknown
  function automatic int route_index(input logic [ADDR_W-1:0] dest);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_dest[i] == dest) return i;
    end
    return -1;
  endfunction

  // insert a route or lower its delay, flag a drop when the table is full
  function automatic void learn_route(input logic [ADDR_W-1:0] dest,
                                      input logic [ADDR_W-1:0] gw,
                                      input logic [DELAY_W-1:0] cost);
    int idx;
    idx = route_index(dest);
    if (idx >= 0) begin
      if (cost < tbl_delay[idx]) tbl_delay[idx] = cost;
    end else if (tbl_count < TABLE_SLOTS) begin
      tbl_dest[tbl_count] = dest;
      tbl_gw[tbl_count] = gw;
      tbl_delay[tbl_count] = cost;
      tbl_count++;
    end else begin
      pkt_drop = 1'b1;
    end
  endfunction

  // update the predicted table for one transaction, return 1 if it answers
  function automatic bit predict_route_reply(input route_item_t it,
                                             output route_reply_t rep);
    int idx;
    logic [DELAY_W:0] sum;
    rep = '0;
    case (it.kind)
      KIND_LOOKUP: begin
        idx = route_index(it.addr);
        if (idx >= 0) begin
          rep.kind = RES_FOUND;
          rep.gw = tbl_gw[idx];
          rep.dly = tbl_delay[idx];
        end else begin
          rep.kind = RES_NO_ROUTE;
        end
        return 1'b1;
      end
      KIND_HEADER: begin
        pkt_drop = 1'b0;
        pkt_gw = it.addr;
        pkt_link = it.dly;
        learn_route(it.addr, it.addr, it.dly);
      end
      KIND_ENTRY: begin
        if (it.addr != my_addr) begin
          sum = {1'b0, pkt_link} + {1'b0, it.dly};
          if (sum[DELAY_W]) sum[DELAY_W-1:0] = '1;
          learn_route(it.addr, pkt_gw, sum[DELAY_W-1:0]);
        end
      end
      default: return 1'b0;
    endcase
    if (!it.last_ent) return 1'b0;
    rep.kind = RES_ACK;
    rep.drop = pkt_drop;
    return 1'b1;
  endfunction

  task automatic offer(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                       input logic [DELAY_W-1:0] dly, input logic last_ent);
    route_item_t it;
    it.kind = kind;
    it.addr = addr;
    it.dly = dly;
    it.last_ent = last_ent;
    route_items.insert(route_items.size(), it);
  endtask

  // mostly known neighbours, sometimes our own address or a stranger
  function automatic logic [ADDR_W-1:0] pick_addr();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
    if (roll < 80) return my_addr;
    return ADDR_W'($urandom);
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) return DELAY_W'($urandom_range(0, 63));
    if (roll < 60) return DELAY_W'($urandom_range(0, 4095));
    if (roll < 75) return DELAY_W'($urandom_range(16'hFF00, 16'hFFFF));
    return DELAY_W'($urandom);
  endfunction

  // mostly well formed routing packets, plus lookups, broken sequences and unused item kinds
  task automatic queue_random_traffic(input int n_items);
    int made, n_ent, roll, k;
    made = 0;
    while (made < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        n_ent = $urandom_range(0, 6);
        offer(KIND_HEADER, pick_addr(), pick_delay(), n_ent == 0);
        for (k = 0; k < n_ent; k++) begin
          offer(KIND_ENTRY, pick_addr(), pick_delay(), k == n_ent - 1);
        end
        made += n_ent + 1;
      end else if (roll < 85) begin
        offer(KIND_LOOKUP, pick_addr(), DELAY_W'($urandom), 1'($urandom));
        made++;
      end else if (roll < 93) begin
        // stray entry or a header whose packet may never close
        offer(roll[0] ? KIND_ENTRY : KIND_HEADER, pick_addr(), pick_delay(), 1'($urandom));
        made++;
      end else begin
        offer(KIND_UNUSED, ADDR_W'($urandom), DELAY_W'($urandom), 1'($urandom));
        made++;
      end
    end
  endtask

  // wait until the block is empty and has finished any silent work
  task automatic drain_and_settle();
    do @(posedge clk);
    while (route_items.size() != 0 || in_valid || pending_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_own_address(input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    my_addr = value;
    n_settings++;
  endtask

  task automatic check_field(input string name, input logic [DELAY_W-1:0] want,
                             input logic [DELAY_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  // driver: present queued transactions, predict on acceptance
  always @(posedge clk) begin
    route_item_t  it;
    route_reply_t rep;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        it.kind = in_kind;
        it.addr = in_address;
        it.dly = in_delay_value;
        it.last_ent = in_last_entry;
        if (predict_route_reply(it, rep)) pending_replies.insert(pending_replies.size(), rep);
        void'(route_items.pop_front());
        items_sent++;
      end
      if (in_valid && !in_ready) begin
        in_valid <= 1'b1;
      end else if (route_items.size() != 0 &&
                   (steady_flow || $urandom_range(0, 99) >= 33)) begin
        in_valid <= 1'b1;
        in_kind <= route_items[0].kind;
        in_address <= route_items[0].addr;
        in_delay_value <= route_items[0].dly;
        in_last_entry <= route_items[0].last_ent;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare results in order, hold off once to back up the block
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk) begin
    route_reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        reply_cnt++;
        case (out_result_kind)
          RES_FOUND:    n_found++;
          RES_NO_ROUTE: n_no_route++;
          RES_ACK:      n_ack++;
          default:      ;
        endcase
        if (out_table_full_dropped === 1'b1) n_dropped++;
        if (pending_replies.size() == 0) begin
          $error("unexpected result transaction, kind %0d", out_result_kind);
          fail_cnt++;
        end else begin
          want = pending_replies.pop_front();
          check_field("result_kind", DELAY_W'(want.kind), DELAY_W'(out_result_kind));
          check_field("gateway", want.gw, out_gateway);
          check_field("route_delay", want.dly, out_route_delay);
          check_field("table_full_dropped", DELAY_W'(want.drop),
                      DELAY_W'(out_table_full_dropped));
        end
      end
      if (!hold_done && reply_cnt >= HOLD_OFF_AT) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[distance_vector_route_table_top] ERROR");
        $finish;
      end
    end
  end

  // stimulus and phase control
  initial begin
    logic [ADDR_W-1:0] phase_addr [6];
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = ADDR_W'($urandom);
    phase_addr[0] = '1;
    phase_addr[1] = addr_pool[2];
    phase_addr[2] = ADDR_W'($urandom);
    phase_addr[3] = addr_pool[7];
    phase_addr[4] = '0;
    phase_addr[5] = ADDR_W'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    set_own_address('0);

    // directed: empty table, stray entry, own address, saturation, improvement
    offer(KIND_LOOKUP, 16'h0000, 16'h0000, 1'b0);
    offer(KIND_ENTRY, 16'h1234, 16'h0005, 1'b1);
    offer(KIND_ENTRY, 16'h0000, 16'h0007, 1'b1);
    offer(KIND_HEADER, 16'hFFFF, 16'hFFFF, 1'b0);
    offer(KIND_ENTRY, 16'h0001, 16'hFFFF, 1'b0);
    offer(KIND_ENTRY, 16'h1234, 16'h0001, 1'b1);
    offer(KIND_HEADER, 16'h00A0, 16'h0003, 1'b0);
    offer(KIND_ENTRY, 16'h1234, 16'h0001, 1'b1);
    offer(KIND_LOOKUP, 16'h1234, 16'h0000, 1'b0);
    offer(KIND_LOOKUP, 16'h0001, 16'hFFFF, 1'b1);
    offer(KIND_HEADER, 16'hFFFF, 16'h0002, 1'b1);
    offer(KIND_LOOKUP, 16'hFFFF, 16'hFFFF, 1'b1);
    offer(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    offer(KIND_HEADER, 16'h0000, 16'h0000, 1'b1);
    offer(KIND_LOOKUP, 16'h0000, 16'h0000, 1'b0);
    offer(KIND_HEADER, 16'h5555, 16'hAAAA, 1'b0);
    offer(KIND_ENTRY, 16'hAAAA, 16'h5555, 1'b0);
    offer(KIND_LOOKUP, 16'h00A0, 16'h0000, 1'b0);
    offer(KIND_LOOKUP, 16'hAAAA, 16'h0000, 1'b0);
    drain_and_settle();

    // random phases, each under its own address setting
    for (int p = 0; p < 6; p++) begin
      set_own_address(phase_addr[p]);
      steady_flow = (p == 3);
      queue_random_traffic(PHASE_ITEMS);
      drain_and_settle();
    end
    steady_flow = 1'b0;

    $display("run covered %0d input transactions over %0d own address settings",
             items_sent, n_settings);
    $display("results: %0d found, %0d no route, %0d acks (%0d with drops)",
             n_found, n_no_route, n_ack, n_dropped);
    if (fail_cnt == 0) begin
      $display("[distance_vector_route_table_top] OK");
    end else begin
      $display("[distance_vector_route_table_top] ERROR");
    end
    $finish;
  end

endmodule
